// ===== rtl/core/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the lattice coordinate converter.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int VW     = 32;   // vector component width
   localparam int FW     = 21;   // packed Q11.10 field width
   localparam int RW     = 63;   // configuration register width
   localparam int NSW    = 88;   // signed numerator width
   localparam int DW     = 64;   // signed divisor width
   localparam int NW     = 98;   // divider remainder width
   localparam int DIV_STEPS = 33;   // quotient bits resolved by the divider
   localparam int ALAT   = 4;    // arithmetic front stages
   localparam int DLAT   = DIV_STEPS + 3;
   localparam int LAT    = ALAT + DLAT;
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int CAW    = 3;
   localparam int F2C_DEN = 1024;

   typedef enum logic [CAW-1:0] {
      CSR_ROW0, CSR_ROW1, CSR_ROW2, CSR_ORIGIN, CSR_START, CSR_EXTENT, CSR_MODE
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_BOX_C2F, OP_ORT_C2F, OP_BOX_F2C, OP_ORT_F2C
   } op_type;

   typedef struct packed {
      op_type               op;
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [RW-1:0] row0;
      logic [RW-1:0] row1;
      logic [RW-1:0] row2;
      logic [RW-1:0] origin;
      logic [RW-1:0] start;
      logic [RW-1:0] extent;
   } cfg_type;

   function automatic logic signed [FW-1:0] fld(input logic [RW-1:0] r, input int k);
      return $signed(r[FW*k +: FW]);
   endfunction

endpackage

// ===== rtl/core/lcc_req_if.sv =====
// ----------------------------------------------------------------------------
// lcc_req_if
// Request channel: direction and one vector.
// ----------------------------------------------------------------------------
interface lcc_req_if import lcc_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic signed [VW-1:0] vec_x;
   logic signed [VW-1:0] vec_y;
   logic signed [VW-1:0] vec_z;

   modport source (output valid, action, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, action, vec_x, vec_y, vec_z, output ready);
endinterface

// ===== rtl/core/lcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lcc_rsp_if
// Response channel: converted vector and singular flag.
// ----------------------------------------------------------------------------
interface lcc_rsp_if import lcc_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic signed [VW-1:0] res_x;
   logic signed [VW-1:0] res_y;
   logic signed [VW-1:0] res_z;
   logic                 singular;

   modport source (output valid, res_x, res_y, res_z, singular, input ready);
   modport sink   (input valid, res_x, res_y, res_z, singular, output ready);
endinterface

// ===== rtl/core/lattice_coordinate_converter.sv =====
// ----------------------------------------------------------------------------
// lattice_coordinate_converter
// Cartesian <-> fractional conversion of one 3-vector per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while the input queue is not full and returns
// one response per request, in order. A request leaving the four-entry input
// queue passes the 33-stage restoring divider in each lane before it reaches
// the response register. Stalls on the response side freeze the whole back
// pipeline; the queue keeps accepting until it is full.
module lattice_coordinate_converter import lcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   lcc_req_if.sink          req_chan,
   lcc_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CAW-1:0]   csr_index,
   input  logic [RW-1:0]    csr_wr_data
);
   cfg_type   cfg_ff, cfg_in;
   logic      mode_ff, mode_in;
   head_type  head;
   logic      en, pop;

   logic signed [NSW-1:0] num [3];
   logic signed [DW-1:0]  den [3];
   logic                  sing;
   logic [VW-1:0]         lane [3];

   logic      vld_ff [LAT];
   logic      sng_ff [DLAT];
   logic      rsp_v_ff, rsp_v_in;
   logic [VW-1:0] rx_ff, ry_ff, rz_ff;
   logic      rs_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      mode_in = mode_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_ROW0:   cfg_in.row0   = csr_wr_data;
            CSR_ROW1:   cfg_in.row1   = csr_wr_data;
            CSR_ROW2:   cfg_in.row2   = csr_wr_data;
            CSR_ORIGIN: cfg_in.origin = csr_wr_data;
            CSR_START:  cfg_in.start  = csr_wr_data;
            CSR_EXTENT: cfg_in.extent = csr_wr_data;
            CSR_MODE:   mode_in       = csr_wr_data[0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         mode_ff <= mode_in;
      end
   end

   assign en  = !rsp_v_ff || rsp_chan.ready;
   assign pop = en && head.valid;

   lcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .box_mode (mode_ff),
      .pop      (pop),
      .head     (head)
   );

   lcc_arith u_arith (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .item  (head.item),
      .num   (num),
      .den   (den),
      .sing  (sing)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      lcc_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num[i]),
         .den   (den[i]),
         .res   (lane[i])
      );
   end

   // advance request valid and singular flag alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= head.valid;
         for (int s = 1; s < LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
      if (en) begin
         sng_ff[0] <= sing;
         for (int s = 1; s < DLAT; s++) begin
            sng_ff[s] <= sng_ff[s-1];
         end
      end
   end

   assign rsp_v_in = en ? vld_ff[LAT-1] : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
      if (en) begin
         rx_ff <= sng_ff[DLAT-1] ? '0 : lane[0];
         ry_ff <= sng_ff[DLAT-1] ? '0 : lane[1];
         rz_ff <= sng_ff[DLAT-1] ? '0 : lane[2];
         rs_ff <= sng_ff[DLAT-1];
      end
   end

   assign rsp_chan.valid    = rsp_v_ff;
   assign rsp_chan.res_x    = $signed(rx_ff);
   assign rsp_chan.res_y    = $signed(ry_ff);
   assign rsp_chan.res_z    = $signed(rz_ff);
   assign rsp_chan.singular = rs_ff;

`ifndef SYNTHESIS
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rs_ff) |-> (rx_ff == '0 && ry_ff == '0 && rz_ff == '0))
      else $error("singular response with nonzero components");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      (en && !vld_ff[LAT-1]) |=> !rsp_v_ff)
      else $error("response raised from an empty pipeline slot");

   a_queue: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> head.valid)
      else $error("accepted request missing from queue");
`endif
endmodule

// ===== rtl/core/lcc_front.sv =====
// ----------------------------------------------------------------------------
// lcc_front
// Accepts requests, classifies the operation and queues them.
// ----------------------------------------------------------------------------
module lcc_front import lcc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   lcc_req_if.sink req,
   input  logic   box_mode,
   input  logic   pop,
   output head_type head
);
   item_type         mem_ff [QDEPTH];
   logic [QAW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]     cnt_ff, cnt_in;
   logic             push, do_pop;
   item_type         item;

   assign req.ready = (cnt_ff != (QAW+1)'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign do_pop    = pop && (cnt_ff != '0);

   always_comb begin
      if (req.action) begin
         item.op = box_mode ? OP_BOX_F2C : OP_ORT_F2C;
      end else begin
         item.op = box_mode ? OP_BOX_C2F : OP_ORT_C2F;
      end
      item.x = req.vec_x;
      item.y = req.vec_y;
      item.z = req.vec_z;
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QAW+1)'(push) - (QAW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= item;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = mem_ff[rp_ff];
endmodule

// ===== rtl/core/lcc_arith.sv =====
// ----------------------------------------------------------------------------
// lcc_arith
// Builds numerator and divisor per lane and one singular flag in four stages.
// ----------------------------------------------------------------------------
module lcc_arith import lcc_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  cfg_type               cfg,
   input  item_type              item,
   output logic signed [NSW-1:0] num [3],
   output logic signed [DW-1:0]  den [3],
   output logic                  sing
);
   logic signed [FW-1:0] m [3][3];
   logic signed [FW-1:0] e [3];
   logic signed [FW-1:0] org [3];
   logic signed [FW-1:0] st [3];
   logic [RW-1:0]        rows [3];
   logic signed [VW-1:0] v0 [3];

   // stage 1
   logic signed [41:0] pa_ff [3][3], pa_in [3][3];
   logic signed [41:0] pb_ff [3][3], pb_in [3][3];
   logic signed [52:0] fp_ff [3][3], fp_in [3][3];
   logic signed [52:0] ep_ff [3], ep_in [3];
   logic signed [VW-1:0] v1_ff [3];
   op_type             op1_ff;
   // stage 2
   logic signed [41:0] c_ff [3][3], c_in [3][3];
   logic signed [55:0] t2_ff [3], t2_in [3];
   logic signed [VW-1:0] v2_ff [3];
   op_type             op2_ff;
   logic               ez2_ff, ez2_in;
   // stage 3
   logic signed [41:0] dh_ff [3], dh_in [3];
   logic signed [42:0] dl_ff [3], dl_in [3];
   logic signed [52:0] ah_ff [3][3], ah_in [3][3];
   logic signed [53:0] al_ff [3][3], al_in [3][3];
   logic signed [55:0] t3_ff [3];
   logic signed [VW-1:0] v3_ff [3];
   op_type             op3_ff;
   logic               ez3_ff;
   // stage 4
   logic signed [NSW-1:0] num_ff [3], num_in [3];
   logic signed [DW-1:0]  den_ff [3], den_in [3];
   logic                  sing_ff, sing_in;
   logic signed [DW-1:0]  det;
   logic signed [NSW-1:0] acc [3];

   assign rows = '{cfg.row0, cfg.row1, cfg.row2};
   assign v0   = '{item.x, item.y, item.z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e[i]   = fld(cfg.extent, i);
         org[i] = fld(cfg.origin, i);
         st[i]  = fld(cfg.start, i);
         for (int j = 0; j < 3; j++) begin
            m[i][j] = fld(rows[i], j);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pa_in[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3];
            pb_in[i][j] = m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
            fp_in[i][j] = v0[i] * m[i][j];
         end
         ep_in[i] = v0[i] * e[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c_in[i][j] = pa_ff[i][j] - pb_ff[i][j];
         end
         if (op1_ff == OP_BOX_F2C) begin
            t2_in[i] = 56'(fp_ff[0][i]) + 56'(fp_ff[1][i]) + 56'(fp_ff[2][i])
                     + (56'(org[i]) <<< 20);
         end else begin
            t2_in[i] = 56'(ep_ff[i]) + (56'(st[i]) <<< 20);
         end
      end
      ez2_in = (e[0] == '0) || (e[1] == '0) || (e[2] == '0);
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dh_in[j] = m[0][j] * $signed(c_ff[0][j][41:21]);
         dl_in[j] = m[0][j] * $signed({1'b0, c_ff[0][j][20:0]});
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ah_in[i][j] = $signed(c_ff[i][j][41:21]) * v2_ff[j];
            al_in[i][j] = $signed({1'b0, c_ff[i][j][20:0]}) * v2_ff[j];
         end
      end
   end

   always_comb begin
      det = '0;
      for (int j = 0; j < 3; j++) begin
         det = det + (DW'(dh_ff[j]) <<< 21) + DW'(dl_ff[j]);
      end
      for (int i = 0; i < 3; i++) begin
         acc[i] = '0;
         for (int j = 0; j < 3; j++) begin
            acc[i] = acc[i] + (NSW'(ah_ff[i][j]) <<< 21) + NSW'(al_ff[i][j]);
         end
      end
      sing_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         case (op3_ff)
            OP_BOX_C2F: begin
               num_in[i] = acc[i] <<< 10;
               den_in[i] = det;
            end
            OP_ORT_C2F: begin
               num_in[i] = NSW'(v3_ff[i]) <<< 10;
               den_in[i] = DW'(e[i]);
            end
            default: begin
               num_in[i] = NSW'(t3_ff[i]);
               den_in[i] = DW'(F2C_DEN);
            end
         endcase
      end
      case (op3_ff)
         OP_BOX_C2F: sing_in = (det == '0);
         OP_ORT_C2F: sing_in = ez3_ff;
         default:    sing_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         fp_ff   <= fp_in;
         ep_ff   <= ep_in;
         v1_ff   <= v0;
         op1_ff  <= item.op;
         c_ff    <= c_in;
         t2_ff   <= t2_in;
         v2_ff   <= v1_ff;
         op2_ff  <= op1_ff;
         ez2_ff  <= ez2_in;
         dh_ff   <= dh_in;
         dl_ff   <= dl_in;
         ah_ff   <= ah_in;
         al_ff   <= al_in;
         t3_ff   <= t2_ff;
         v3_ff   <= v2_ff;
         op3_ff  <= op2_ff;
         ez3_ff  <= ez2_ff;
         num_ff  <= num_in;
         den_ff  <= den_in;
         sing_ff <= sing_in;
      end
   end

   assign num  = num_ff;
   assign den  = den_ff;
   assign sing = sing_ff;
endmodule

// ===== rtl/core/lcc_div.sv =====
// ----------------------------------------------------------------------------
// lcc_div
// Pipelined restoring divider with round-half-away and 32-bit saturation.
// ----------------------------------------------------------------------------
module lcc_div import lcc_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [NSW-1:0] num,
   input  logic signed [DW-1:0]  den,
   output logic [VW-1:0]         res
);
   logic [NSW-1:0] nabs;
   logic [DW-1:0]  dabs;
   logic [NW-1:0]  nm_ff;
   logic [DW-1:0]  dm_ff;
   logic           pneg_ff;
   logic           ovf_in;

   logic [NW-1:0]        r_ff   [DIV_STEPS+1];
   logic [DW-1:0]        d_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   logic                 neg_ff [DIV_STEPS+1];
   logic                 ovf_ff [DIV_STEPS+1];

   logic               up;
   logic [DIV_STEPS:0] qf;
   logic [VW-1:0]      res_ff, res_in;

   assign nabs   = num[NSW-1] ? NSW'(-num) : NSW'(num);
   assign dabs   = den[DW-1] ? DW'(-den) : DW'(den);
   assign ovf_in = nm_ff >= (NW'(dm_ff) << DIV_STEPS);

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff     <= NW'(nabs);
         dm_ff     <= dabs;
         pneg_ff   <= num[NSW-1] ^ den[DW-1];
         r_ff[0]   <= nm_ff;
         d_ff[0]   <= dm_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= pneg_ff;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      localparam int K = DIV_STEPS - s;
      logic [NW-1:0]        dk;
      logic                 ge;
      logic [NW-1:0]        r_in;
      logic [DIV_STEPS-1:0] q_in;

      assign dk = NW'(d_ff[s-1]) << K;
      assign ge = r_ff[s-1] >= dk;
      always_comb begin
         r_in    = ge ? r_ff[s-1] - dk : r_ff[s-1];
         q_in    = q_ff[s-1];
         q_in[K] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_in;
            d_ff[s]   <= d_ff[s-1];
            q_ff[s]   <= q_in;
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign up = {r_ff[DIV_STEPS][DW-1:0], 1'b0} >= {1'b0, d_ff[DIV_STEPS]};
   assign qf = {1'b0, q_ff[DIV_STEPS]} + (DIV_STEPS+1)'(up);

   always_comb begin
      if (neg_ff[DIV_STEPS]) begin
         if (ovf_ff[DIV_STEPS] || qf > (DIV_STEPS+1)'(64'h8000_0000)) begin
            res_in = 32'h8000_0000;
         end else begin
            res_in = VW'(-qf[VW-1:0]);
         end
      end else begin
         if (ovf_ff[DIV_STEPS] || qf > (DIV_STEPS+1)'(64'h7FFF_FFFF)) begin
            res_in = 32'h7FFF_FFFF;
         end else begin
            res_in = qf[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;
endmodule
